// ===== rtl/kcm_pkg.sv =====
// Shared widths, codes and nucleotide helpers for the k-mer canonical minimizer unit.
package kcm_pkg;

	// Fixed field widths
	localparam int KMER_W = 62;
	localparam int MINI_W = 30;
	localparam int POS_W  = 5;
	localparam int HASH_W = 64;

	// Number of register stages ahead of the compare tree: canonical plus four hash stages
	localparam int FRONT_STAGES = 5;

	// Complement of a 2-bit nucleotide code is an XOR with this mask
	localparam logic [1:0] NUC_COMP = 2'b10;

	// Reverse complement of the low nuc nucleotides of w, right aligned
	function automatic logic [HASH_W-1:0] kcm_revcomp(input logic [HASH_W-1:0] w,
			input int nuc);
		logic [HASH_W-1:0] r;
		r = '0;
		for (int j = 0; j < HASH_W / 2; j++) begin
			if (j < nuc) begin
				r[2 * (nuc - 1 - j) +: 2] = w[2 * j +: 2] ^ NUC_COMP;
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/kmer_canonical_minimizer_unit.sv =====
// Top level: pipelined canonical minimizer of one k-mer per cycle unless stalled.
//
// Returns the canonical minimizer and window index of each k-mer it takes.
// Over W = KMER_LEN - MINI_LEN + 1 windows (W = 1 when MINI_LEN > KMER_LEN, 17 at the
// defaults): one stage builds every canonical window, four stages run the 64-bit hash
// on all windows in parallel, and a registered min tree picks the winner, one tree
// level per stage. One request is taken per cycle while the pipe is not stalled; a
// stall on the result side holds each stage that is full and lets bubbles fill, so
// kmer_ready stays high while the pipe has a hole.
// Lowest window index wins on equal hashes.
module kmer_canonical_minimizer_unit
	import kcm_pkg::*;
#(
	parameter int KMER_LEN = 31,
	parameter int MINI_LEN = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              kmer_valid,
	output logic              kmer_ready,
	input  logic [KMER_W-1:0] kmer,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [MINI_W-1:0] minimizer,
	output logic [POS_W-1:0]  position
);

	localparam int NUM_WIN = (MINI_LEN > KMER_LEN) ? 1 : KMER_LEN - MINI_LEN + 1;
	localparam int LV      = (NUM_WIN > 1) ? $clog2(NUM_WIN) : 0;
	localparam int P       = 1 << LV;
	localparam int NST     = FRONT_STAGES + LV;
	localparam int WW      = 2 * MINI_LEN;

	// Stage valids, ready chain and load enables
	logic [NST-1:0] v_q;
	logic [NST-1:0] rdy;
	logic [NST-1:0] ld;

	always_comb begin
		rdy[NST-1] = !v_q[NST-1] || result_ready;
		for (int i = NST - 2; i >= 0; i--) begin
			rdy[i] = !v_q[i] || rdy[i+1];
		end
	end

	always_comb begin
		ld[0] = rdy[0] && kmer_valid;
		for (int i = 1; i < NST; i++) begin
			ld[i] = rdy[i] && v_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) begin
				v_q[0] <= kmer_valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (rdy[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	assign kmer_ready   = rdy[0];
	assign result_valid = v_q[NST-1];

	// Stage 1: window extraction and canonical form
	logic [HASH_W-1:0] seq;
	logic [WW-1:0]     canon_d [NUM_WIN];
	logic [WW-1:0]     win_s1  [NUM_WIN];

	assign seq = HASH_W'(kmer);

	for (genvar gi = 0; gi < NUM_WIN; gi++) begin : g_win
		logic [WW-1:0]     raw;
		logic [HASH_W-1:0] rc_wide;
		logic [WW-1:0]     rc;
		assign raw     = seq[2 * gi +: WW];
		assign rc_wide = kcm_revcomp(HASH_W'(raw), MINI_LEN);
		assign rc      = rc_wide[WW-1:0];
		assign canon_d[gi] = (rc < raw) ? rc : raw;
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			for (int i = 0; i < NUM_WIN; i++) begin
				win_s1[i] <= canon_d[i];
			end
		end
	end

	// Stages 2 to 5: shift-add-xor hash, one add group per stage
	logic [HASH_W-1:0] h2_d [NUM_WIN];
	logic [HASH_W-1:0] h3_d [NUM_WIN];
	logic [HASH_W-1:0] h4_d [NUM_WIN];
	logic [HASH_W-1:0] h5_d [NUM_WIN];
	logic [HASH_W-1:0] hsh_s2 [NUM_WIN];
	logic [HASH_W-1:0] hsh_s3 [NUM_WIN];
	logic [HASH_W-1:0] hsh_s4 [NUM_WIN];
	logic [HASH_W-1:0] hsh_s5 [NUM_WIN];
	logic [WW-1:0]     win_s2 [NUM_WIN];
	logic [WW-1:0]     win_s3 [NUM_WIN];
	logic [WW-1:0]     win_s4 [NUM_WIN];
	logic [WW-1:0]     win_s5 [NUM_WIN];

	always_comb begin : hash_mix
		logic [HASH_W-1:0] k;
		logic [HASH_W-1:0] a;
		for (int i = 0; i < NUM_WIN; i++) begin
			k       = HASH_W'(win_s1[i]);
			h2_d[i] = (~k) + (k << 21);
			a       = hsh_s2[i] ^ (hsh_s2[i] >> 24);
			h3_d[i] = a + (a << 3) + (a << 8);
			a       = hsh_s3[i] ^ (hsh_s3[i] >> 14);
			h4_d[i] = a + (a << 2) + (a << 4);
			a       = hsh_s4[i] ^ (hsh_s4[i] >> 28);
			h5_d[i] = a + (a << 31);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_WIN; i++) begin
			if (ld[1]) begin
				hsh_s2[i] <= h2_d[i];
				win_s2[i] <= win_s1[i];
			end
			if (ld[2]) begin
				hsh_s3[i] <= h3_d[i];
				win_s3[i] <= win_s2[i];
			end
			if (ld[3]) begin
				hsh_s4[i] <= h4_d[i];
				win_s4[i] <= win_s3[i];
			end
			if (ld[4]) begin
				hsh_s5[i] <= h5_d[i];
				win_s5[i] <= win_s4[i];
			end
		end
	end

	// Registered min tree, one level per stage; left child wins ties
	if (LV > 0) begin : g_tree
		localparam int NN = 2 * P - 1;
		logic [HASH_W-1:0] nh [NN];
		logic [WW-1:0]     nw [NN];
		logic [POS_W-1:0]  np [NN];
		logic [HASH_W-1:0] nh_q [P-1];
		logic [WW-1:0]     nw_q [P-1];
		logic [POS_W-1:0]  np_q [P-1];
		logic [HASH_W-1:0] best_wide;

		// Leaves; pad slots copy window 0, which never changes the answer
		for (genvar gk = 0; gk < P; gk++) begin : g_leaf
			if (gk < NUM_WIN) begin : g_real
				assign nh[P-1+gk] = hsh_s5[gk];
				assign nw[P-1+gk] = win_s5[gk];
				assign np[P-1+gk] = POS_W'(gk);
			end else begin : g_pad
				assign nh[P-1+gk] = hsh_s5[0];
				assign nw[P-1+gk] = win_s5[0];
				assign np[P-1+gk] = '0;
			end
		end

		for (genvar gn = 0; gn < P - 1; gn++) begin : g_node
			localparam int DEPTH = $clog2(gn + 2) - 1;
			localparam int STG   = FRONT_STAGES - 1 + LV - DEPTH;
			logic pick_r;
			assign pick_r = nh[2*gn+2] < nh[2*gn+1];
			assign nh[gn] = nh_q[gn];
			assign nw[gn] = nw_q[gn];
			assign np[gn] = np_q[gn];
			always_ff @(posedge clk) begin
				if (ld[STG]) begin
					nh_q[gn] <= pick_r ? nh[2*gn+2] : nh[2*gn+1];
					nw_q[gn] <= pick_r ? nw[2*gn+2] : nw[2*gn+1];
					np_q[gn] <= pick_r ? np[2*gn+2] : np[2*gn+1];
				end
			end
		end

		assign best_wide = HASH_W'(nw[0]);
		assign minimizer = best_wide[MINI_W-1:0];
		assign position  = np[0];
	end else begin : g_single
		logic [HASH_W-1:0] best_wide;
		assign best_wide = HASH_W'(win_s5[0]);
		assign minimizer = best_wide[MINI_W-1:0];
		assign position  = '0;
	end

endmodule

// ===== rtl/kcm_checker.sv =====
// Port-level checker for the k-mer canonical minimizer unit, with its bind.
module kcm_checker
	import kcm_pkg::*;
#(
	parameter int KMER_LEN = 31,
	parameter int MINI_LEN = 15
) (
	input logic              clk,
	input logic              arst_n,
	input logic              kmer_valid,
	input logic              kmer_ready,
	input logic [KMER_W-1:0] kmer,
	input logic              result_valid,
	input logic              result_ready,
	input logic [MINI_W-1:0] minimizer,
	input logic [POS_W-1:0]  position
);

	localparam int WW      = 2 * MINI_LEN;
	localparam int LAST    = (MINI_LEN > KMER_LEN) ? 0 : KMER_LEN - MINI_LEN;

	logic [HASH_W-1:0] mini_wide;
	logic [HASH_W-1:0] mini_rc;

	assign mini_wide = HASH_W'(minimizer);
	assign mini_rc   = kcm_revcomp(mini_wide, MINI_LEN);

	// A waiting request holds its k-mer until taken
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		kmer_valid && !kmer_ready |=> kmer_valid && $stable(kmer))
		else $error("request dropped or changed while waiting");

	// A stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(minimizer)
			&& $stable(position))
		else $error("result changed while stalled");

	// An empty output stage means the whole pipe can take a request
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> kmer_ready)
		else $error("input stalled with empty output stage");

	// Position is a real window index
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> 32'(position) <= LAST)
		else $error("position beyond last window");

	// Result is canonical: not above its own reverse complement
	a_canon: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (WW > MINI_W) || (mini_wide <= mini_rc))
		else $error("minimizer not canonical");

endmodule

bind kmer_canonical_minimizer_unit kcm_checker #(
	.KMER_LEN(KMER_LEN),
	.MINI_LEN(MINI_LEN)
) u_kcm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.kmer_valid  (kmer_valid),
	.kmer_ready  (kmer_ready),
	.kmer        (kmer),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.minimizer   (minimizer),
	.position    (position)
);

// ===== test/minimizer_check.sv =====
`timescale 1ns / 1ps
// Result monitor for the k-mer canonical minimizer unit: predicts each result and compares it.
module minimizer_check
	import kcm_pkg::*;
#(
	parameter int KMER_LEN = 31,
	parameter int MINI_LEN = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              kmer_valid,
	input  logic              kmer_ready,
	input  logic [KMER_W-1:0] kmer,
	input  logic              result_valid,
	input  logic              result_ready,
	input  logic [MINI_W-1:0] minimizer,
	input  logic [POS_W-1:0]  position,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [MINI_W-1:0] mini;
		logic [POS_W-1:0]  pos;
	} minimizer_t;

	typedef struct {
		minimizer_t        res;
		logic [KMER_W-1:0] src;
	} due_entry_t;

	// Expected results, oldest first, tagged with the k-mer they came from
	due_entry_t minimizer_due[$];
	int errs = 0;

	// Reverse complement of a MINI_LEN window, right aligned
	function automatic logic [63:0] rev_comp(logic [63:0] w);
		logic [63:0] r;
		r = '0;
		for (int n = 0; n < MINI_LEN; n++) begin
			r = (r << 2) | 64'(w[1:0] ^ NUC_COMP);
			w = w >> 2;
		end
		return r;
	endfunction

	// 64-bit shift-add-xor integer hash, wraps modulo 2^64
	function automatic logic [63:0] mix_hash(logic [63:0] key);
		key = (~key) + (key << 21);
		key = key ^ (key >> 24);
		key = (key + (key << 3)) + (key << 8);
		key = key ^ (key >> 14);
		key = (key + (key << 2)) + (key << 4);
		key = key ^ (key >> 28);
		key = key + (key << 31);
		return key;
	endfunction

	// Canonical window with the least hash; strict compare keeps the lowest position on ties
	function automatic minimizer_t canonical_minimizer(logic [KMER_W-1:0] seq);
		logic [63:0] mask, fwd, w, best, best_hash, h;
		int          last;
		minimizer_t  r;
		mask = (64'd1 << (2 * MINI_LEN)) - 64'd1;
		last = (MINI_LEN > KMER_LEN) ? 0 : KMER_LEN - MINI_LEN;
		fwd = 64'(seq) & mask;
		w = rev_comp(fwd);
		best = (w < fwd) ? w : fwd;
		best_hash = mix_hash(best);
		r.pos = '0;
		for (int i = 1; i <= last && i < 32; i++) begin
			fwd = (64'(seq) >> (2 * i)) & mask;
			w = rev_comp(fwd);
			if (fwd < w) begin
				w = fwd;
			end
			h = mix_hash(w);
			if (h < best_hash) begin
				best_hash = h;
				best = w;
				r.pos = POS_W'(i);
			end
		end
		r.mini = best[MINI_W-1:0];
		return r;
	endfunction

	task automatic report(string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errs++;
	endtask

	// Sample both channels at the clock edge
	always @(posedge clk) begin : watch
		due_entry_t e;
		if (arst_n) begin
			if (kmer_valid && kmer_ready) begin
				e.src = kmer;
				e.res = canonical_minimizer(kmer);
				minimizer_due.push_back(e);
			end
			if (result_valid && result_ready) begin
				if (minimizer_due.size() == 0) begin
					report($sformatf("result %h/%0d with no request waiting", minimizer, position));
				end else begin
					e = minimizer_due.pop_front();
					if (minimizer !== e.res.mini) begin
						report($sformatf("kmer %h: minimizer %h, expected %h",
							e.src, minimizer, e.res.mini));
					end
					if (position !== e.res.pos) begin
						report($sformatf("kmer %h: position %0d, expected %0d",
							e.src, position, e.res.pos));
					end
				end
			end
		end
		fail_count <= errs;
		pending <= minimizer_due.size();
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the k-mer canonical minimizer unit: stimulus, flow control and verdict.
module tb;
	import kcm_pkg::*;

	localparam int KMER_LEN    = 31;
	localparam int MINI_LEN    = 15;
	localparam int N_RANDOM    = 1150;
	localparam int HOLD_AT     = 320;
	localparam int HOLD_CYCLES = 80;
	localparam int N_CORNER    = 22;

	// Corner k-mers: uniform runs, palindromic repeats, ties, single nucleotides, edges
	localparam logic [63:0] CORNER_KMERS [N_CORNER] = '{
		64'h0000_0000_0000_0000,
		64'h3fff_ffff_ffff_ffff,
		64'h1555_5555_5555_5555,
		64'h2aaa_aaaa_aaaa_aaaa,
		64'h2222_2222_2222_2222,
		64'h3777_7777_7777_7777,
		64'h0000_0000_0000_0003,
		64'h3000_0000_0000_0000,
		64'h0000_0000_0000_0001,
		64'h1000_0000_0000_0000,
		64'h0000_0000_3000_0000,
		64'h0000_0003_0000_0000,
		64'h0123_4567_89ab_cdef,
		64'h3edc_ba98_7654_3210,
		64'h3ccc_cccc_cccc_cccc,
		64'h0f0f_0f0f_0f0f_0f0f,
		64'h30f0_f0f0_f0f0_f0f0,
		64'h3fff_ffff_0000_0000,
		64'h0000_0000_ffff_ffff,
		64'h0000_0000_3fff_ffff,
		64'h1b1b_1b1b_1b1b_1b1b,
		64'h24e4_e4e4_e4e4_e4e4
	};

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              kmer_valid   = 1'b0;
	logic [KMER_W-1:0] kmer         = '0;
	logic              result_ready = 1'b0;
	wire               kmer_ready;
	wire               result_valid;
	wire  [MINI_W-1:0] minimizer;
	wire  [POS_W-1:0]  position;
	int                fail_count;
	int                pending;
	int                sent_count   = 0;

	kmer_canonical_minimizer_unit #(
		.KMER_LEN(KMER_LEN),
		.MINI_LEN(MINI_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.kmer_valid(kmer_valid),
		.kmer_ready(kmer_ready),
		.kmer(kmer),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.minimizer(minimizer),
		.position(position)
	);

	minimizer_check #(
		.KMER_LEN(KMER_LEN),
		.MINI_LEN(MINI_LEN)
	) mon (
		.clk(clk),
		.arst_n(arst_n),
		.kmer_valid(kmer_valid),
		.kmer_ready(kmer_ready),
		.kmer(kmer),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.minimizer(minimizer),
		.position(position),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one k-mer and hold it until accepted
	task automatic send_kmer(logic [63:0] v);
		kmer_valid <= 1'b1;
		kmer <= v[KMER_W-1:0];
		do @(posedge clk); while (!kmer_ready);
		sent_count++;
	endtask

	task automatic pause_sender(int n);
		kmer_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Random k-mer: half uniform, some short repeats (ties), sparse, or two-letter alphabets
	function automatic logic [63:0] random_kmer();
		logic [63:0] v;
		logic [31:0] pat;
		int          kind, plen;
		v = {$urandom, $urandom};
		kind = $urandom_range(0, 99);
		if (kind >= 50 && kind < 70) begin
			pat = $urandom;
			plen = $urandom_range(1, 6);
			for (int n = 0; n < 32; n++) begin
				v[2 * n +: 2] = pat[2 * (n % plen) +: 2];
			end
		end else if (kind >= 70 && kind < 85) begin
			v = v & {$urandom, $urandom} & {$urandom, $urandom};
		end else if (kind >= 85) begin
			v = ($urandom_range(0, 1) == 0) ? v & {32{2'b01}} : v | {32{2'b10}};
		end
		return v;
	endfunction

	// Sender: directed corners, then random k-mers, in bursts
	initial begin
		int          burst_left;
		int          gap;
		logic [63:0] v;
		burst_left = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_CORNER + N_RANDOM; i++) begin
			v = (i < N_CORNER) ? CORNER_KMERS[i] : random_kmer();
			if (burst_left == 0) begin
				// no gaps around the long receiver hold so the pipe fills up
				if (i >= HOLD_AT - 20 && i < HOLD_AT + 200) begin
					gap = 0;
				end else begin
					gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
				if (gap > 0) begin
					pause_sender(gap);
				end
				burst_left = $urandom_range(1, 40);
			end
			burst_left--;
			send_kmer(v);
		end
		kmer_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS kmer_canonical_minimizer_unit");
		end else begin
			$display("FAIL kmer_canonical_minimizer_unit");
		end
		$finish;
	end

	// Receiver: random stall phases, plus one long hold once traffic is flowing
	initial begin
		int phase_left;
		int pct;
		int hold_left;
		bit held;
		phase_left = 0;
		pct = 100;
		hold_left = 0;
		held = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (!held && sent_count >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				if (phase_left == 0) begin
					phase_left = $urandom_range(20, 200);
					case ($urandom_range(0, 3))
						0: pct = 100;
						1: pct = 70;
						2: pct = 40;
						default: pct = 10;
					endcase
				end
				phase_left--;
				result_ready <= ($urandom_range(0, 99) < pct);
			end
			@(posedge clk);
		end
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("FAIL kmer_canonical_minimizer_unit");
		$finish;
	end

endmodule
